// ----- rtl/fcou_pkg.sv -----
// ----------------------------------------------------------------------------
// fcou_pkg
// Types, constants and tables shared by the fly camera orientation core.
// ----------------------------------------------------------------------------
package fcou_pkg;

	// configuration register indexes
	localparam logic CFG_LOOK_GAIN = 1'b0;
	localparam logic CFG_MOVE_STEP = 1'b1;

	// angle constants, Q9.7 degrees
	localparam logic signed [21:0] ANG_FULL    = 22'sd46080;
	localparam logic signed [21:0] ANG_HALF    = 22'sd23040;
	localparam logic signed [16:0] ANG_QUARTER = 17'sd11520;
	localparam logic signed [21:0] PITCH_LIMIT = 22'sd11392;
	localparam logic signed [15:0] YAW_RESET   = -16'sd11520;

	// unit length in Q1.14
	localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

	// cordic seed, Q30 gain corrected
	localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
	localparam int CORDIC_STEPS = 16;

	// reset values
	localparam logic [15:0] LOOK_GAIN_RESET = 16'd6554;
	localparam logic [15:0] MOVE_STEP_RESET = 16'd328;
	localparam logic signed [31:0] POS_X_RESET = 32'sd65536;
	localparam logic signed [31:0] POS_Y_RESET = 32'sd45875;
	localparam logic signed [31:0] POS_Z_RESET = 32'sd275251;

	// input word
	typedef struct packed {
		logic              op;
		logic signed [15:0] delta_x;
		logic signed [15:0] delta_y;
		logic              key_forward;
		logic              key_back;
		logic              key_left;
		logic              key_right;
	} in_word_t;

	// result word
	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] front_x;
		logic signed [15:0] front_y;
		logic signed [15:0] front_z;
	} out_word_t;

	// cordic result
	typedef struct packed {
		logic              done;
		logic signed [31:0] cos_v;
		logic signed [31:0] sin_v;
	} cordic_res_t;

	// root / divide unit
	typedef enum logic {
		RD_SQRT = 1'b0,
		RD_DIV  = 1'b1
	} rd_mode_t;

	typedef struct packed {
		logic        start;
		rd_mode_t    mode;
		logic [45:0] radicand;
		logic [16:0] numer;
		logic [23:0] divisor;
	} rd_req_t;

	typedef struct packed {
		logic        done;
		logic [23:0] value;
	} rd_res_t;

	// arctangent of 2^-i in Q.16 degrees
	function automatic logic [21:0] atan_deg(input logic [3:0] i);
		logic [21:0] r;
		unique case (i)
			4'd0:  r = 22'd2949120;
			4'd1:  r = 22'd1740967;
			4'd2:  r = 22'd919879;
			4'd3:  r = 22'd466945;
			4'd4:  r = 22'd234379;
			4'd5:  r = 22'd117304;
			4'd6:  r = 22'd58666;
			4'd7:  r = 22'd29335;
			4'd8:  r = 22'd14668;
			4'd9:  r = 22'd7334;
			4'd10: r = 22'd3667;
			4'd11: r = 22'd1833;
			4'd12: r = 22'd917;
			4'd13: r = 22'd458;
			4'd14: r = 22'd229;
			default: r = 22'd115;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/fcou_cordic.sv -----
// ----------------------------------------------------------------------------
// fcou_cordic
// Iterative rotation cordic: sine and cosine of a Q9.7 degree angle in Q30.
// ----------------------------------------------------------------------------
module fcou_cordic (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [15:0]   angle,
	output fcou_pkg::cordic_res_t res
);
	import fcou_pkg::*;

	logic               busy_q;
	logic               done_q;
	logic               neg_q;
	logic [3:0]         cnt_q;
	logic signed [33:0] x_q, y_q;
	logic signed [25:0] z_q;
	logic signed [31:0] cos_q, sin_q;

	logic signed [16:0] a_ext, a_fold;
	logic               a_neg;
	logic signed [33:0] xs, ys, xn, yn, xf, yf;
	logic signed [25:0] at, zn;

	// fold into plus or minus 90 degrees
	always_comb begin
		a_ext  = {angle[15], angle};
		a_fold = a_ext;
		a_neg  = 1'b0;
		if (a_ext > ANG_QUARTER) begin
			a_fold = a_ext - 17'sd23040;
			a_neg  = 1'b1;
		end else if (a_ext < -ANG_QUARTER) begin
			a_fold = a_ext + 17'sd23040;
			a_neg  = 1'b1;
		end
	end

	// one micro-rotation
	always_comb begin
		xs = x_q >>> cnt_q;
		ys = y_q >>> cnt_q;
		at = $signed({4'd0, atan_deg(cnt_q)});
		if (z_q >= 26'sd0) begin
			xn = x_q - ys;
			yn = y_q + xs;
			zn = z_q - at;
		end else begin
			xn = x_q + ys;
			yn = y_q - xs;
			zn = z_q + at;
		end
		xf = neg_q ? -xn : xn;
		yf = neg_q ? -yn : yn;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= CORDIC_X0;
			y_q   <= '0;
			z_q   <= {a_fold, 9'd0};
			neg_q <= a_neg;
		end else if (busy_q) begin
			x_q <= xn;
			y_q <= yn;
			z_q <= zn;
			if (cnt_q == 4'(CORDIC_STEPS - 1)) begin
				cos_q <= xf[31:0];
				sin_q <= yf[31:0];
			end
		end
	end

	assign res = '{done: done_q, cos_v: cos_q, sin_v: sin_q};

endmodule

// ----- rtl/fcou_rootdiv.sv -----
// ----------------------------------------------------------------------------
// fcou_rootdiv
// Shared subtractor running a bitwise square root or a restoring divide.
// ----------------------------------------------------------------------------
module fcou_rootdiv (
	input  logic              clk,
	input  logic              arst_n,
	input  fcou_pkg::rd_req_t req,
	output fcou_pkg::rd_res_t res
);
	import fcou_pkg::*;

	localparam logic [5:0] SQRT_LAST = 6'd22;
	localparam logic [5:0] DIV_LAST  = 6'd36;

	logic        busy_q;
	logic        done_q;
	rd_mode_t    mode_q;
	logic [5:0]  cnt_q;
	logic [46:0] rem_q;
	logic [46:0] res_q;
	logic [46:0] aux_q;
	logic [23:0] div_q;

	logic [46:0] sub_a, sub_b;
	logic [47:0] diff;
	logic        ge;
	logic [24:0] shifted;
	logic [36:0] dividend;
	logic [23:0] q_clamp;

	// operand select for the shared subtractor
	always_comb begin
		shifted = {rem_q[23:0], aux_q[36]};
		if (mode_q == RD_SQRT) begin
			sub_a = rem_q;
			sub_b = res_q + aux_q;
		end else begin
			sub_a = {22'd0, shifted};
			sub_b = {23'd0, div_q};
		end
		diff = {1'b0, sub_a} - {1'b0, sub_b};
		ge   = !diff[47];
	end

	// rounded dividend: numer << 22 plus half the divisor
	always_comb begin
		dividend = {req.numer[14:0], 22'd0} + {14'd0, req.divisor[23:1]};
		if (req.numer[16:15] != 2'd0) begin
			dividend = {req.numer[14:0], 22'd0} + {14'd0, req.divisor[23:1]}
				+ {req.numer[15], 36'd0};
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			mode_q <= RD_SQRT;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				mode_q <= req.mode;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if ((mode_q == RD_SQRT && cnt_q == SQRT_LAST) ||
					(mode_q == RD_DIV && cnt_q == DIV_LAST)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			res_q <= '0;
			div_q <= req.divisor;
			if (req.mode == RD_SQRT) begin
				rem_q <= {1'b0, req.radicand};
				aux_q <= 47'd1 << 44;
			end else begin
				rem_q <= '0;
				aux_q <= {10'd0, dividend};
			end
		end else if (busy_q) begin
			if (mode_q == RD_SQRT) begin
				if (ge) begin
					rem_q <= diff[46:0];
					res_q <= (res_q >> 1) + aux_q;
				end else begin
					res_q <= res_q >> 1;
				end
				aux_q <= aux_q >> 2;
			end else begin
				rem_q <= ge ? diff[46:0] : {22'd0, shifted};
				res_q <= {res_q[45:0], ge};
				aux_q <= {aux_q[45:0], 1'b0};
			end
		end
	end

	// quotient clamp to one
	always_comb begin
		if (res_q[36:0] > 37'd16384) q_clamp = 24'd16384;
		else q_clamp = res_q[23:0];
	end

	assign res = '{done: done_q, value: (mode_q == RD_SQRT) ? res_q[23:0] : q_clamp};

endmodule

// ----- rtl/fly_camera_orientation_update_core.sv -----
// ----------------------------------------------------------------------------
// fly_camera_orientation_update_core
// Yaw/pitch fly camera: look items turn the view, move items step position.
//
//   channel | signals                       | word
//   --------+-------------------------------+-----------------------------
//   in      | in_valid, in_ready, in_data   | op, mouse deltas, move keys
//   out     | out_valid, out_ready, out_data| position and front vector
//   cfg     | cfg_we, cfg_index, cfg_data   | look_gain, move_step
//
// One word in flight. A look word takes up to 6 wrap steps of yaw and
// two cordic runs. A move word takes a multiply and an add per moved
// component, and for the strafe axis a square root and two divides.
// Reset is asynchronous active low and restores the camera pose and gains.
// in_ready is high only while idle; a finished word waits for a free
// output register, which a stalled out_ready holds.
// ----------------------------------------------------------------------------
module fly_camera_orientation_update_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  fcou_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output fcou_pkg::out_word_t out_data,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_data
);
	import fcou_pkg::*;

	typedef enum logic [19:0] {
		S_IDLE = 20'h00001,
		S_LMX  = 20'h00002,
		S_LMY  = 20'h00004,
		S_LPIT = 20'h00008,
		S_WRAP = 20'h00010,
		S_CY   = 20'h00020,
		S_CP   = 20'h00040,
		S_FX   = 20'h00080,
		S_FZ   = 20'h00100,
		S_FZW  = 20'h00200,
		S_MSEL = 20'h00400,
		S_MMUL = 20'h00800,
		S_MADD = 20'h01000,
		S_SQX  = 20'h02000,
		S_SQZ  = 20'h04000,
		S_SQS  = 20'h08000,
		S_ROOT = 20'h10000,
		S_DV1  = 20'h20000,
		S_DV2  = 20'h40000,
		S_DONE = 20'h80000
	} state_t;

	state_t state_q, state_d;

	logic [15:0]        look_gain_q, move_step_q;
	in_word_t           item_q;
	logic signed [15:0] yaw_q, pitch_q;
	logic signed [31:0] pos_q [3];
	logic signed [15:0] front_q [3];
	logic signed [21:0] acc_q;
	logic signed [31:0] cy_q, sy_q, cp_q;
	logic [29:0]        n2_q;
	logic [23:0]        len_q;
	logic signed [15:0] sx_q, sz_q;
	logic [1:0]         phase_q;
	logic [1:0]         k_q;
	logic signed [63:0] mul_q;
	logic               out_valid_q;
	out_word_t          out_q;

	logic signed [31:0] mul_a, mul_b;
	logic               cordic_start;
	logic signed [15:0] cordic_angle;
	cordic_res_t        cres;
	rd_req_t            rd_req;
	rd_res_t            rd_res;

	// shared units
	fcou_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.angle  (cordic_angle),
		.res    (cres)
	);

	fcou_rootdiv u_rootdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rd_req),
		.res    (rd_res)
	);

	// rounding of products
	logic signed [34:0] r13;
	logic signed [20:0] ang_d;
	logic signed [64:0] r46;
	logic signed [18:0] f46;
	logic signed [15:0] f46_c;
	logic signed [32:0] r16;
	logic signed [16:0] fy;
	logic signed [15:0] fy_c;
	logic signed [33:0] r14;
	logic signed [19:0] mv_d;
	logic signed [21:0] pitch_sum;
	logic signed [15:0] pitch_c;
	logic signed [15:0] vec_k;
	logic signed [32:0] pos_sum;
	logic signed [31:0] pos_sat;
	logic               sub_dir;
	logic               key_sel;
	logic [29:0]        n2_sum;
	logic signed [15:0] q_pos, q_neg;

	always_comb begin
		r13   = {mul_q[33], mul_q[33:0]} + 35'sd4096;
		ang_d = r13[33:13];
		r46   = {mul_q[63], mul_q} + (65'sd1 <<< 45);
		f46   = r46[64:46];
		if (f46 > 19'sd16384) f46_c = ONE_Q14;
		else if (f46 < -19'sd16384) f46_c = -ONE_Q14;
		else f46_c = f46[15:0];
		r16 = {cres.sin_v[31], cres.sin_v} + 33'sd32768;
		fy  = r16[32:16];
		if (fy > 17'sd16384) fy_c = ONE_Q14;
		else if (fy < -17'sd16384) fy_c = -ONE_Q14;
		else fy_c = fy[15:0];
		r14  = {mul_q[32], mul_q[32:0]} + 34'sd8192;
		mv_d = r14[33:14];
		pitch_sum = {{6{pitch_q[15]}}, pitch_q} + {ang_d[20], ang_d};
		if (pitch_sum > PITCH_LIMIT) pitch_c = PITCH_LIMIT[15:0];
		else if (pitch_sum < -PITCH_LIMIT) pitch_c = -PITCH_LIMIT[15:0];
		else pitch_c = pitch_sum[15:0];
		n2_sum = n2_q + mul_q[29:0];
		q_pos  = $signed(rd_res.value[15:0]);
		q_neg  = -q_pos;
	end

	// move component select and saturating add
	always_comb begin
		if (phase_q[1] == 1'b0) begin
			vec_k = (k_q == 2'd2) ? front_q[2] : (k_q == 2'd1) ? front_q[1] : front_q[0];
		end else begin
			vec_k = (k_q == 2'd2) ? sz_q : (k_q == 2'd1) ? 16'sd0 : sx_q;
		end
		sub_dir = (phase_q == 2'd1) || (phase_q == 2'd2);
		unique case (phase_q)
			2'd0: key_sel = item_q.key_forward;
			2'd1: key_sel = item_q.key_back;
			2'd2: key_sel = item_q.key_left;
			default: key_sel = item_q.key_right;
		endcase
		pos_sum = sub_dir ?
			({pos_q[k_q][31], pos_q[k_q]} - {{13{mv_d[19]}}, mv_d}) :
			({pos_q[k_q][31], pos_q[k_q]} + {{13{mv_d[19]}}, mv_d});
		if (pos_sum[32] != pos_sum[31]) pos_sat = pos_sum[32] ? 32'sh80000000 : 32'sh7fffffff;
		else pos_sat = pos_sum[31:0];
	end

	// multiplier operands, unit requests and next state
	always_comb begin
		state_d      = state_q;
		mul_a        = '0;
		mul_b        = '0;
		cordic_start = 1'b0;
		cordic_angle = acc_q[15:0];
		rd_req       = '{start: 1'b0, mode: RD_SQRT, radicand: {n2_sum, 16'd0},
			numer: 17'd0, divisor: len_q};
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = in_data.op ? S_MSEL : S_LMX;
			end
			S_LMX: begin
				mul_a   = {{16{item_q.delta_x[15]}}, item_q.delta_x};
				mul_b   = {16'd0, look_gain_q};
				state_d = S_LMY;
			end
			S_LMY: begin
				mul_a   = {{16{item_q.delta_y[15]}}, item_q.delta_y};
				mul_b   = {16'd0, look_gain_q};
				state_d = S_LPIT;
			end
			S_LPIT: state_d = S_WRAP;
			S_WRAP: begin
				if (acc_q < ANG_HALF && acc_q >= -ANG_HALF) begin
					cordic_start = 1'b1;
					state_d      = S_CY;
				end
			end
			S_CY: begin
				cordic_angle = pitch_q;
				if (cres.done) begin
					cordic_start = 1'b1;
					state_d      = S_CP;
				end
			end
			S_CP: begin
				if (cres.done) state_d = S_FX;
			end
			S_FX: begin
				mul_a   = cy_q;
				mul_b   = cp_q;
				state_d = S_FZ;
			end
			S_FZ: begin
				mul_a   = sy_q;
				mul_b   = cp_q;
				state_d = S_FZW;
			end
			S_FZW: state_d = S_DONE;
			S_MSEL: begin
				if (key_sel) state_d = S_MMUL;
				else if (phase_q == 2'd1) state_d = (item_q.key_left || item_q.key_right) ?
					S_SQX : S_DONE;
				else if (phase_q == 2'd3) state_d = S_DONE;
			end
			S_MMUL: begin
				mul_a   = {{16{vec_k[15]}}, vec_k};
				mul_b   = {16'd0, move_step_q};
				state_d = S_MADD;
			end
			S_MADD: begin
				if (k_q != 2'd2) state_d = S_MMUL;
				else if (phase_q == 2'd1) state_d = (item_q.key_left || item_q.key_right) ?
					S_SQX : S_DONE;
				else if (phase_q == 2'd3) state_d = S_DONE;
				else state_d = S_MSEL;
			end
			S_SQX: begin
				mul_a   = {{16{front_q[0][15]}}, front_q[0]};
				mul_b   = {{16{front_q[0][15]}}, front_q[0]};
				state_d = S_SQZ;
			end
			S_SQZ: begin
				mul_a   = {{16{front_q[2][15]}}, front_q[2]};
				mul_b   = {{16{front_q[2][15]}}, front_q[2]};
				state_d = S_SQS;
			end
			S_SQS: begin
				rd_req.start = 1'b1;
				state_d      = S_ROOT;
			end
			S_ROOT: begin
				if (rd_res.done) begin
					if (rd_res.value == 24'd0) begin
						state_d = S_MSEL;
					end else begin
						rd_req.start   = 1'b1;
						rd_req.mode    = RD_DIV;
						rd_req.numer   = front_q[2][15] ? -{front_q[2][15], front_q[2]} :
							{front_q[2][15], front_q[2]};
						rd_req.divisor = rd_res.value;
						state_d        = S_DV1;
					end
				end
			end
			S_DV1: begin
				if (rd_res.done) begin
					rd_req.start = 1'b1;
					rd_req.mode  = RD_DIV;
					rd_req.numer = front_q[0][15] ? -{front_q[0][15], front_q[0]} :
						{front_q[0][15], front_q[0]};
					state_d      = S_DV2;
				end
			end
			S_DV2: begin
				if (rd_res.done) state_d = S_MSEL;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control state and camera pose
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			look_gain_q <= LOOK_GAIN_RESET;
			move_step_q <= MOVE_STEP_RESET;
			yaw_q       <= YAW_RESET;
			pitch_q     <= '0;
			pos_q[0]    <= POS_X_RESET;
			pos_q[1]    <= POS_Y_RESET;
			pos_q[2]    <= POS_Z_RESET;
			front_q[0]  <= '0;
			front_q[1]  <= '0;
			front_q[2]  <= -ONE_Q14;
			phase_q     <= '0;
			k_q         <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == CFG_LOOK_GAIN) look_gain_q <= cfg_data;
				else move_step_q <= cfg_data;
			end
			// output register: load a finished word, else drain on ready
			if (state_q == S_DONE && (!out_valid_q || out_ready)) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					phase_q <= '0;
					k_q     <= '0;
				end
				S_LPIT: pitch_q <= pitch_c;
				S_WRAP: begin
					if (acc_q < ANG_HALF && acc_q >= -ANG_HALF) yaw_q <= acc_q[15:0];
				end
				S_CP: begin
					if (cres.done) front_q[1] <= fy_c;
				end
				S_FZ: front_q[0] <= f46_c;
				S_FZW: front_q[2] <= f46_c;
				S_MSEL: begin
					k_q <= '0;
					if (!key_sel) phase_q <= phase_q + 2'd1;
				end
				S_MADD: begin
					pos_q[k_q] <= pos_sat;
					if (k_q == 2'd2) begin
						k_q     <= '0;
						phase_q <= phase_q + 2'd1;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				S_ROOT: begin
					if (rd_res.done && rd_res.value == 24'd0) phase_q <= 2'd2;
				end
				S_DV2: begin
					if (rd_res.done) phase_q <= 2'd2;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		if (state_q == S_IDLE && in_valid) item_q <= in_data;
		if (state_q == S_LMY) acc_q <= {{6{yaw_q[15]}}, yaw_q} + {ang_d[20], ang_d};
		if (state_q == S_WRAP) begin
			if (acc_q >= ANG_HALF) acc_q <= acc_q - ANG_FULL;
			else if (acc_q < -ANG_HALF) acc_q <= acc_q + ANG_FULL;
		end
		if (state_q == S_CY && cres.done) begin
			cy_q <= cres.cos_v;
			sy_q <= cres.sin_v;
		end
		if (state_q == S_CP && cres.done) cp_q <= cres.cos_v;
		if (state_q == S_SQZ) n2_q <= mul_q[29:0];
		if (state_q == S_ROOT && rd_res.done) begin
			len_q <= rd_res.value;
			sx_q  <= '0;
			sz_q  <= '0;
		end
		if (state_q == S_DV1 && rd_res.done) sx_q <= front_q[2][15] ? q_pos : q_neg;
		if (state_q == S_DV2 && rd_res.done) sz_q <= front_q[0][15] ? q_neg : q_pos;
		if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			out_q <= '{pos_x: pos_q[0], pos_y: pos_q[1], pos_z: pos_q[2],
				front_x: front_q[0], front_y: front_q[1], front_z: front_q[2]};
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// checks
	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pitch_q <= PITCH_LIMIT) && (pitch_q >= -PITCH_LIMIT))
		else $error("pitch out of range");
	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		(yaw_q >= -16'sd23040) && (yaw_q < 16'sd23040))
		else $error("yaw out of range");
	a_front_unit: assert property (@(posedge clk) disable iff (!arst_n)
		(front_q[0] <= ONE_Q14) && (front_q[0] >= -ONE_Q14) &&
		(front_q[2] <= ONE_Q14) && (front_q[2] >= -ONE_Q14))
		else $error("front component beyond unit");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("ready while a word is in work");
	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && (!out_valid_q || out_ready)) |=> out_valid)
		else $error("result lost");

endmodule
